@@ src/cfc_pkg.sv @@
// Shared types, constants and helpers for the caster friction compensation block.
package cfc_pkg;

  localparam int CASTERS    = 4;
  localparam int LAST_INDEX = CASTERS - 1;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  localparam logic [15:0] COULOMB_RESET   = 16'd13107;
  localparam logic [15:0] VISCOUS_RESET   = 16'd6554;
  localparam logic [15:0] INV_ROLL_RESET  = 16'd2621;
  localparam logic [30:0] THRESH_RESET    = 31'd39322;
  localparam logic [30:0] INV_THR_RESET   = 31'd109227;
  localparam logic [16:0] RATIO_ONE       = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COULOMB  = 3'd0,
    CFG_VISCOUS  = 3'd1,
    CFG_INV_ROLL = 3'd2,
    CFG_THRESH   = 3'd3,
    CFG_INV_THR  = 3'd4
  } cfg_reg_t;

  // Operand pair presented to the shared multiplier
  typedef enum logic [2:0] {
    MUL_ROLL,
    MUL_TORQ,
    MUL_COUL,
    MUL_VISC,
    MUL_STEER,
    MUL_COMP
  } mul_op_t;

  // Register loaded from the previous cycle's product
  typedef enum logic [2:0] {
    WB_NONE,
    WB_FRD,
    WB_RATIO,
    WB_B,
    WB_M,
    WB_RAW,
    WB_OUT
  } wb_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROLL,
    S_TORQ,
    S_COUL,
    S_VISC,
    S_M,
    S_STEER,
    S_RAW,
    S_COMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    load_in;
    mul_op_t mul_op;
    wb_t     wb;
  } dp_cmd_t;

  // Clamp a signed 50-bit value into the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v[49:31] == '0 || v[49:31] == '1) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

@@ src/cfc_ctrl.sv @@
// Sequencer for the caster friction compensation datapath.
module cfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cfc_pkg::dp_cmd_t cmd
);
  import cfc_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.load_in    = 1'b0;
    cmd.mul_op     = MUL_ROLL;
    cmd.wb         = WB_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_ROLL;
      end
      S_ROLL: begin
        cmd.mul_op = MUL_ROLL;
        state_next = S_TORQ;
      end
      S_TORQ: begin
        cmd.mul_op = MUL_TORQ;
        cmd.wb     = WB_FRD;
        state_next = S_COUL;
      end
      S_COUL: begin
        cmd.mul_op = MUL_COUL;
        cmd.wb     = WB_RATIO;
        state_next = S_VISC;
      end
      S_VISC: begin
        cmd.mul_op = MUL_VISC;
        cmd.wb     = WB_B;
        state_next = S_M;
      end
      S_M: begin
        cmd.mul_op = MUL_VISC;
        cmd.wb     = WB_M;
        state_next = S_STEER;
      end
      S_STEER: begin
        cmd.mul_op = MUL_STEER;
        state_next = S_RAW;
      end
      S_RAW: begin
        cmd.mul_op = MUL_STEER;
        cmd.wb     = WB_RAW;
        state_next = S_COMP;
      end
      S_COMP: begin
        cmd.mul_op = MUL_COMP;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold the product until the output register is free
        cmd.mul_op = MUL_COMP;
        if (!out_valid || out_ready) begin
          cmd.wb         = WB_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/cfc_datapath.sv @@
// Operand registers, shared multiplier, config registers and output register.
module cfc_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  cfc_pkg::dp_cmd_t                 cmd,
  input  logic                             cfg_we,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       caster_index,
  input  logic signed [31:0]               steer_rate,
  input  logic signed [31:0]               roll_rate,
  input  logic signed [31:0]               commanded_torque,
  output logic signed [31:0]               compensation_torque,
  output logic signed [31:0]               running_total,
  output logic                             total_valid
);
  import cfc_pkg::*;

  logic [15:0] coulomb_coeff, viscous_coeff, inv_roll_rate_limit;
  logic [30:0] torque_threshold, inv_torque_threshold;

  logic [1:0]         idx;
  logic signed [31:0] steer;
  logic [31:0]        aroll, atq;
  logic signed [31:0] frd, b, m, raw, torque_sum;
  logic [16:0]        ratio;
  logic signed [65:0] prod;

  logic signed [32:0] a_op, b_op;
  logic signed [31:0] vis, comp, total;
  logic signed [31:0] frd_next, raw_next;
  logic [16:0]        ratio_next;
  logic               steer_pos, last;

  always_ff @(posedge clk) begin
    if (rst) begin
      coulomb_coeff        <= COULOMB_RESET;
      viscous_coeff        <= VISCOUS_RESET;
      inv_roll_rate_limit  <= INV_ROLL_RESET;
      torque_threshold     <= THRESH_RESET;
      inv_torque_threshold <= INV_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COULOMB:  coulomb_coeff        <= cfg_data[15:0];
        CFG_VISCOUS:  viscous_coeff        <= cfg_data[15:0];
        CFG_INV_ROLL: inv_roll_rate_limit  <= cfg_data[15:0];
        CFG_THRESH:   torque_threshold     <= cfg_data;
        CFG_INV_THR:  inv_torque_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cmd.mul_op)
      MUL_ROLL: begin
        a_op = {1'b0, aroll};
        b_op = {17'b0, inv_roll_rate_limit};
      end
      MUL_TORQ: begin
        a_op = {1'b0, atq};
        b_op = {2'b0, inv_torque_threshold};
      end
      MUL_COUL: begin
        a_op = {17'b0, coulomb_coeff};
        b_op = {frd[31], frd};
      end
      MUL_VISC: begin
        a_op = {17'b0, viscous_coeff};
        b_op = {frd[31], frd};
      end
      MUL_STEER: begin
        a_op = {m[31], m};
        b_op = {steer[31], steer};
      end
      MUL_COMP: begin
        a_op = {raw[31], raw};
        b_op = {16'b0, ratio};
      end
      default: ;
    endcase
  end

  // Each product is registered and read in the next cycle through its right-shift slice
  assign frd_next  = 32'sh0001_0000 - $signed({1'b0, prod[46:16]});
  assign ratio_next = (atq >= {1'b0, torque_threshold}) ? RATIO_ONE :
                      (prod[62:16] > 47'd65536)         ? RATIO_ONE : prod[32:16];
  assign vis       = sat32(prod[65:16]);
  assign steer_pos = !steer[31] && (steer != '0);
  assign raw_next  = steer_pos ?
      sat32({{18{vis[31]}}, vis} + {{18{b[31]}}, b}) :
      sat32({{18{vis[31]}}, vis} - {{18{b[31]}}, b});
  assign comp      = prod[47:16];
  assign total     = sat32({{18{torque_sum[31]}}, torque_sum} + {{18{comp[31]}}, comp});
  assign last      = ({30'b0, idx} >= 32'(LAST_INDEX));

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    if (cmd.load_in) begin
      idx   <= caster_index;
      steer <= steer_rate;
      aroll <= roll_rate[31] ? (~roll_rate + 32'd1) : roll_rate;
      atq   <= commanded_torque[31] ? (~commanded_torque + 32'd1) : commanded_torque;
    end
    case (cmd.wb)
      WB_FRD:   frd   <= frd_next;
      WB_RATIO: ratio <= ratio_next;
      WB_B:     b     <= prod[47:16];
      WB_M:     m     <= prod[47:16];
      WB_RAW:   raw   <= raw_next;
      WB_OUT: begin
        compensation_torque <= comp;
        running_total       <= total;
        total_valid         <= last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      torque_sum <= '0;
    end else if (cmd.wb == WB_OUT) begin
      torque_sum <= last ? 32'sd0 : total;
    end
  end

endmodule

@@ src/caster_friction_compensation_top.sv @@
// Top level of the caster friction compensation block.
//
//   channel  signals                                              direction
//   input    in_valid/in_ready, caster_index, steer_rate,         in
//            roll_rate, commanded_torque
//   output   out_valid/out_ready, compensation_torque,            out
//            running_total, total_valid
//   config   cfg_we, cfg_index, cfg_data                          in
//
// An item is accepted only while the sequencer is idle: one 33x33
// multiplier is shared by six products, each registered before use.
// The result sits in an output register; a new item is accepted while it waits,
// and the last step holds until that register has been taken.
// Reset restores the coefficient registers and clears the running sum.
module caster_friction_compensation_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       caster_index,
  input  logic signed [31:0]               steer_rate,
  input  logic signed [31:0]               roll_rate,
  input  logic signed [31:0]               commanded_torque,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               compensation_torque,
  output logic signed [31:0]               running_total,
  output logic                             total_valid,
  input  logic                             cfg_we,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cfc_pkg::*;

  dp_cmd_t cmd;

  cfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cfc_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .caster_index        (caster_index),
    .steer_rate          (steer_rate),
    .roll_rate           (roll_rate),
    .commanded_torque    (commanded_torque),
    .compensation_torque (compensation_torque),
    .running_total       (running_total),
    .total_valid         (total_valid)
  );

endmodule

@@ src/cfc_checker.sv @@
// Port-level checks for the caster friction compensation block, with its bind.
module cfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] compensation_torque
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(compensation_torque))
    else $error("result changed while stalled");

  // one item at a time: in_ready is low after each acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("item accepted while previous item in progress");

  // a fresh result appears only as the sequencer returns to idle
  a_rise_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while busy");

endmodule

bind caster_friction_compensation_top cfc_checker u_cfc_checker (.*);
